FILE: rtl/srng_pkg.sv
package srng_pkg;

	localparam int unsigned WORD_W = 64;
	localparam int unsigned HALF_W = WORD_W / 2;

	localparam logic [WORD_W-1:0] GOLDEN_GAMMA = 64'h9e3779b97f4a7c15;
	localparam logic [WORD_W-1:0] MUL_ONE      = 64'hbf58476d1ce4e5b9;
	localparam logic [WORD_W-1:0] MUL_TWO      = 64'h94d049bb133111eb;
	localparam int unsigned SHIFT_ONE   = 30;
	localparam int unsigned SHIFT_TWO   = 27;
	localparam int unsigned SHIFT_THREE = 31;

	// draw cap for the rejection loop
	localparam int unsigned MAX_DRAWS = 1024;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_LATCH,
		OP_DIV_LIMIT,
		OP_SET_LIMIT,
		OP_MIX_A,
		OP_MUL_LL,
		OP_MUL_LH,
		OP_MUL_HL,
		OP_MIX_B,
		OP_MIX_C,
		OP_DIV_WORD,
		OP_SUM,
		OP_OUT
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic   mul_two;
	} dp_cmd_t;

	typedef struct packed {
		logic is_rng;
		logic bad;
		logic wzero;
		logic word_ok;
		logic div_busy;
	} dp_stat_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_LIM_DIV,
		ST_MIX_A,
		ST_MUL1,
		ST_MIX_B,
		ST_MUL2,
		ST_MIX_C,
		ST_TEST,
		ST_MOD_DIV,
		ST_DONE
	} ctrl_state_t;

	typedef enum logic [1:0] {
		PH_LL,
		PH_LH,
		PH_HL
	} mul_ph_t;

endpackage

FILE: rtl/srng_div.sv
module srng_div import srng_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [WORD_W-1:0] dividend,
	input  logic [WORD_W-1:0] divisor,
	output logic              busy,
	output logic [WORD_W-1:0] rem
);

	localparam int unsigned CNT_W = $clog2(WORD_W + 1);

	logic [CNT_W-1:0]  cnt_q;
	logic [WORD_W-1:0] dvd_q;
	logic [WORD_W-1:0] dsr_q;
	logic [WORD_W-1:0] rem_q;
	logic [WORD_W:0]   trial;
	logic [WORD_W:0]   diff;

	// restoring remainder, one quotient bit per cycle
	assign trial = {rem_q, dvd_q[WORD_W-1]};
	assign diff  = trial - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(WORD_W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			dvd_q <= {dvd_q[WORD_W-2:0], 1'b0};
			rem_q <= diff[WORD_W] ? trial[WORD_W-1:0] : diff[WORD_W-1:0];
		end
	end

	assign busy = (cnt_q != '0);
	assign rem  = rem_q;

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(WORD_W))
		else $error("divider step count out of range");

endmodule

FILE: rtl/srng_dpath.sv
module srng_dpath import srng_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [WORD_W-1:0]        cfg_wdata,
	input  logic                     cmd,
	input  logic signed [WORD_W-1:0] range_low,
	input  logic signed [WORD_W-1:0] range_high,
	input  dp_cmd_t                  dp_cmd,
	output dp_stat_t                 dp_stat,
	output logic [WORD_W-1:0]        raw_word,
	output logic signed [WORD_W-1:0] ranged_value,
	output logic                     status
);

	logic [WORD_W-1:0] gen_q;
	logic [WORD_W-1:0] x_q;
	logic [WORD_W-1:0] acc_q;
	logic [WORD_W-1:0] lo_q;
	logic [WORD_W-1:0] width_q;
	logic [WORD_W-1:0] limit_q;
	logic [WORD_W-1:0] ranged_q;
	logic              cmd_q;
	logic              bad_q;
	logic              wzero_q;
	logic [WORD_W-1:0] raw_q;
	logic [WORD_W-1:0] rng_out_q;
	logic              status_q;

	logic [WORD_W-1:0] width_d;
	logic [WORD_W-1:0] mix_a;
	logic [WORD_W-1:0] mul_k;
	logic [HALF_W-1:0] mul_a;
	logic [HALF_W-1:0] mul_b;
	logic [WORD_W-1:0] prod;
	logic              div_start;
	logic [WORD_W-1:0] div_dvd;
	logic              div_busy;
	logic [WORD_W-1:0] div_rem;

	assign width_d = range_high - range_low + 1'b1;
	assign mix_a   = gen_q + GOLDEN_GAMMA;

	// low 64 bits of x * K from three 32x32 partial products
	assign mul_k = dp_cmd.mul_two ? MUL_TWO : MUL_ONE;
	assign mul_a = (dp_cmd.op == OP_MUL_HL) ? x_q[WORD_W-1:HALF_W] : x_q[HALF_W-1:0];
	assign mul_b = (dp_cmd.op == OP_MUL_LH) ? mul_k[WORD_W-1:HALF_W] : mul_k[HALF_W-1:0];
	assign prod  = {{HALF_W{1'b0}}, mul_a} * {{HALF_W{1'b0}}, mul_b};

	assign div_start = (dp_cmd.op == OP_DIV_LIMIT) || (dp_cmd.op == OP_DIV_WORD);
	assign div_dvd   = (dp_cmd.op == OP_DIV_LIMIT) ? {WORD_W{1'b1}} : gen_q;

	srng_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (width_q),
		.busy     (div_busy),
		.rem      (div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_q <= '0;
		end else if (cfg_we) begin
			gen_q <= cfg_wdata;
		end else if (dp_cmd.op == OP_MIX_C) begin
			gen_q <= acc_q ^ (acc_q >> SHIFT_THREE);
		end
	end

	always_ff @(posedge clk) begin
		case (dp_cmd.op)
			OP_LATCH: begin
				cmd_q    <= cmd;
				lo_q     <= range_low;
				bad_q    <= (range_low > range_high);
				width_q  <= width_d;
				wzero_q  <= (width_d == '0);
				ranged_q <= '0;
			end
			OP_SET_LIMIT: begin
				// all-ones minus remainder
				limit_q <= ~div_rem;
			end
			OP_MIX_A: begin
				x_q <= mix_a ^ (mix_a >> SHIFT_ONE);
			end
			OP_MUL_LL: begin
				acc_q <= prod;
			end
			OP_MUL_LH, OP_MUL_HL: begin
				acc_q <= acc_q + {prod[HALF_W-1:0], {HALF_W{1'b0}}};
			end
			OP_MIX_B: begin
				x_q <= acc_q ^ (acc_q >> SHIFT_TWO);
			end
			OP_SUM: begin
				ranged_q <= lo_q + div_rem;
			end
			OP_OUT: begin
				raw_q     <= gen_q;
				rng_out_q <= (cmd_q && !bad_q && wzero_q) ? gen_q : ranged_q;
				status_q  <= cmd_q & bad_q;
			end
			default: begin
			end
		endcase
	end

	assign dp_stat.is_rng   = cmd_q;
	assign dp_stat.bad      = bad_q;
	assign dp_stat.wzero    = wzero_q;
	assign dp_stat.word_ok  = (gen_q < limit_q);
	assign dp_stat.div_busy = div_busy;

	assign raw_word     = raw_q;
	assign ranged_value = rng_out_q;
	assign status       = status_q;

endmodule

FILE: rtl/srng_ctrl.sv
module srng_ctrl import srng_pkg::*; #(
	parameter int unsigned MAX_DRAWS = srng_pkg::MAX_DRAWS
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	output logic     out_valid,
	input  logic     out_stall,
	output dp_cmd_t  dp_cmd,
	input  dp_stat_t dp_stat
);

	localparam int unsigned CNT_W = $clog2(MAX_DRAWS);

	ctrl_state_t      state_q, state_d;
	mul_ph_t          ph_q;
	logic [CNT_W-1:0] draw_q;
	logic             out_valid_q;
	logic             last_draw;
	logic             take_word;
	logic             out_free;

	assign last_draw = (draw_q == CNT_W'(MAX_DRAWS - 1));
	assign take_word = dp_stat.word_ok || last_draw;
	assign out_free  = !out_valid_q || !out_stall;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				if (!dp_stat.is_rng || dp_stat.wzero) begin
					state_d = dp_stat.is_rng && dp_stat.bad ? ST_DONE : ST_MIX_A;
				end else if (dp_stat.bad) begin
					state_d = ST_DONE;
				end else begin
					state_d = ST_LIM_DIV;
				end
			end
			ST_LIM_DIV: begin
				if (!dp_stat.div_busy) state_d = ST_MIX_A;
			end
			ST_MIX_A: state_d = ST_MUL1;
			ST_MUL1: begin
				if (ph_q == PH_HL) state_d = ST_MIX_B;
			end
			ST_MIX_B: state_d = ST_MUL2;
			ST_MUL2: begin
				if (ph_q == PH_HL) state_d = ST_MIX_C;
			end
			ST_MIX_C: begin
				state_d = (!dp_stat.is_rng || dp_stat.wzero) ? ST_DONE : ST_TEST;
			end
			ST_TEST: begin
				state_d = take_word ? ST_MOD_DIV : ST_MIX_A;
			end
			ST_MOD_DIV: begin
				if (!dp_stat.div_busy) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		dp_cmd.op      = OP_NOP;
		dp_cmd.mul_two = (state_q == ST_MUL2);
		case (state_q)
			ST_IDLE: begin
				if (in_valid) dp_cmd.op = OP_LATCH;
			end
			ST_DECIDE: begin
				if (dp_stat.is_rng && !dp_stat.bad && !dp_stat.wzero) dp_cmd.op = OP_DIV_LIMIT;
			end
			ST_LIM_DIV: begin
				if (!dp_stat.div_busy) dp_cmd.op = OP_SET_LIMIT;
			end
			ST_MIX_A: dp_cmd.op = OP_MIX_A;
			ST_MUL1, ST_MUL2: begin
				case (ph_q)
					PH_LL:   dp_cmd.op = OP_MUL_LL;
					PH_LH:   dp_cmd.op = OP_MUL_LH;
					PH_HL:   dp_cmd.op = OP_MUL_HL;
					default: dp_cmd.op = OP_NOP;
				endcase
			end
			ST_MIX_B: dp_cmd.op = OP_MIX_B;
			ST_MIX_C: dp_cmd.op = OP_MIX_C;
			ST_TEST: begin
				if (take_word) dp_cmd.op = OP_DIV_WORD;
			end
			ST_MOD_DIV: begin
				if (!dp_stat.div_busy) dp_cmd.op = OP_SUM;
			end
			ST_DONE: begin
				if (out_free) dp_cmd.op = OP_OUT;
			end
			default: dp_cmd.op = OP_NOP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ph_q        <= PH_LL;
			draw_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;

			if (state_q == ST_MUL1 || state_q == ST_MUL2) begin
				case (ph_q)
					PH_LL:   ph_q <= PH_LH;
					PH_LH:   ph_q <= PH_HL;
					default: ph_q <= PH_LL;
				endcase
			end

			if (state_q == ST_DECIDE) begin
				draw_q <= '0;
			end else if (state_q == ST_TEST && !take_word) begin
				draw_q <= draw_q + 1'b1;
			end

			if (dp_cmd.op == OP_OUT) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == ST_DECIDE))
		else $error("accepted request did not start decode");

	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		(dp_cmd.op == OP_OUT) |-> (!out_valid_q || !out_stall))
		else $error("result register overwritten while held");

	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(dp_cmd.op == OP_DIV_LIMIT || dp_cmd.op == OP_DIV_WORD) |-> !dp_stat.div_busy)
		else $error("divider restarted while busy");

	a_retry_reject: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TEST && state_d == ST_MIX_A) |-> (!dp_stat.word_ok && !last_draw))
		else $error("retry after an acceptable draw");

endmodule

FILE: rtl/splitmix_rng_uniform_range.sv
// Raw request or full-range draw: one mixer pass (mix A, multiply, mix B, multiply, mix C).
// Ranged request: a rejected draw reruns the mixer, up to MAX_DRAWS draws; two remainder
// passes of the radix-2 divider and the 3-step 32x32 multiplier set its timing.
// Invalid range: result with status set, no draw. Next request is accepted once the result is registered.
// Reset (arst_n low) clears the control and sets the generator state to zero.
module splitmix_rng_uniform_range import srng_pkg::*; #(
	parameter int unsigned MAX_DRAWS = srng_pkg::MAX_DRAWS
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [WORD_W-1:0]        cfg_wdata,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic                     cmd,
	input  logic signed [WORD_W-1:0] range_low,
	input  logic signed [WORD_W-1:0] range_high,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [WORD_W-1:0]        raw_word,
	output logic signed [WORD_W-1:0] ranged_value,
	output logic                     status
);

	dp_cmd_t  dp_cmd;
	dp_stat_t dp_stat;

	srng_ctrl #(
		.MAX_DRAWS (MAX_DRAWS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.dp_cmd    (dp_cmd),
		.dp_stat   (dp_stat)
	);

	srng_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.cmd          (cmd),
		.range_low    (range_low),
		.range_high   (range_high),
		.dp_cmd       (dp_cmd),
		.dp_stat      (dp_stat),
		.raw_word     (raw_word),
		.ranged_value (ranged_value),
		.status       (status)
	);

endmodule
